// ===== src/bfd_pkg.sv =====
// ============================================================================
// bfd_pkg - shared types and helpers for the byte frame deframer
// Phase encoding, configuration and result records, register map and
// small pattern helpers used by the parser and the top level.
// ============================================================================
package bfd_pkg;

    // Results one received byte can cause (tail flush worst case)
    localparam int RES_LIMIT = 4;
    localparam int RES_CNT_W = $clog2(RES_LIMIT + 1);

    // Register map, index = byte address / 4
    localparam logic [2:0] REG_FRAME_MODE   = 3'd0;
    localparam logic [2:0] REG_HEAD_LEN     = 3'd1;
    localparam logic [2:0] REG_HEAD_PATTERN = 3'd2;
    localparam logic [2:0] REG_TAIL_LEN     = 3'd3;
    localparam logic [2:0] REG_TAIL_PATTERN = 3'd4;

    // Framing phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_HEAD = 4'b0010,
        PH_DATA = 4'b0100,
        PH_TAIL = 4'b1000
    } t_phase;

    typedef struct packed {
        logic        frame_mode;
        logic [2:0]  head_len;
        logic [31:0] head_pattern;
        logic [2:0]  tail_len;
        logic [31:0] tail_pattern;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        byte_valid;
        logic        frame_done;
        logic [15:0] frame_length;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [RES_CNT_W-1:0]          cnt;
        t_result [RES_LIMIT-1:0]       item;
    } t_res_set;

    // Byte idx of a 4-byte pattern; zero past the fourth byte
    function automatic logic [7:0] pat_byte(logic [31:0] pat, logic [7:0] idx);
        logic [7:0] b;
        b = 8'd0;
        if (idx < 8'd4) begin
            case (idx[1:0])
                2'd0:    b = pat[7:0];
                2'd1:    b = pat[15:8];
                2'd2:    b = pat[23:16];
                default: b = pat[31:24];
            endcase
        end
        return b;
    endfunction

    // Pattern length in use: zero acts as one, clamp to the maximum
    function automatic logic [3:0] eff_len(logic [2:0] v, logic [3:0] mx);
        logic [3:0] w;
        w = {1'b0, v};
        if (w == 4'd0) begin
            w = 4'd1;
        end else if (w > mx) begin
            w = mx;
        end
        return w;
    endfunction

endpackage

// ===== src/bfd_parser.sv =====
// ============================================================================
// bfd_parser - framing state machine
// Holds phase, match count and payload count; for each processed byte it
// updates the state and produces the full set of results for that byte.
// ============================================================================
module bfd_parser #(
    parameter int MAX_HEAD_LEN = 4,
    parameter int MAX_TAIL_LEN = 4,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [7:0]        i_byte,
    input  bfd_pkg::t_cfg     i_cfg,
    output bfd_pkg::t_res_set o_res
);
    import bfd_pkg::*;

    localparam int CW = COUNT_WIDTH;

    t_phase         r_phase, n_phase;
    logic [7:0]     r_match, n_match;
    logic [CW-1:0]  r_count, n_count;

    logic [CW-1:0]  sat_cnt [RES_LIMIT+1];
    logic [CW:0]    sum     [RES_LIMIT+1];
    logic [3:0]     eh, et;
    logic [7:0]     mcp;
    logic [1:0]     flush_n;
    logic [7:0]     head_b, tail_b;
    t_res_set       res;

    function automatic logic [15:0] clip16(logic [CW-1:0] v);
        return (32'(v) > 32'h0000_FFFF) ? 16'hFFFF : 16'(v);
    endfunction

    // Saturating payload counts for zero to four more bytes
    always_comb begin
        for (int k = 0; k <= RES_LIMIT; k++) begin
            sum[k]     = {1'b0, r_count} + (CW+1)'(k);
            sat_cnt[k] = sum[k][CW] ? {CW{1'b1}} : sum[k][CW-1:0];
        end
    end

    assign eh      = eff_len(i_cfg.head_len, 4'(MAX_HEAD_LEN));
    assign et      = eff_len(i_cfg.tail_len, 4'(MAX_TAIL_LEN));
    assign mcp     = r_match + 8'd1;
    assign flush_n = (r_match >= 8'd3) ? 2'd3 : r_match[1:0];
    assign head_b  = pat_byte(i_cfg.head_pattern, r_match);
    assign tail_b  = pat_byte(i_cfg.tail_pattern, r_match);

    // Next state and result set
    always_comb begin
        n_phase = r_phase;
        n_match = r_match;
        n_count = r_count;
        res     = '0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_byte == pat_byte(i_cfg.head_pattern, 8'd0)) begin
                    if (eh == 4'd1) begin
                        n_phase = PH_DATA;
                        n_match = 8'd0;
                    end else begin
                        n_phase = PH_HEAD;
                        n_match = 8'd1;
                    end
                end
            end
            PH_HEAD: begin
                if (i_byte == head_b) begin
                    if (mcp >= {4'd0, eh}) begin
                        n_phase = PH_DATA;
                        n_match = 8'd0;
                    end else begin
                        n_match = mcp;
                    end
                end else begin
                    n_phase = PH_IDLE;
                    n_match = 8'd0;
                end
            end
            PH_DATA: begin
                if (!i_cfg.frame_mode) begin
                    if (i_byte == pat_byte(i_cfg.tail_pattern, 8'd0)) begin
                        if (et == 4'd1) begin
                            res.cnt                  = RES_CNT_W'(1);
                            res.item[0].frame_done   = 1'b1;
                            res.item[0].frame_length = clip16(r_count);
                            n_phase = PH_IDLE;
                            n_match = 8'd0;
                            n_count = '0;
                        end else begin
                            n_phase = PH_TAIL;
                            n_match = 8'd1;
                        end
                    end else begin
                        res.cnt                  = RES_CNT_W'(1);
                        res.item[0].payload_byte = i_byte;
                        res.item[0].byte_valid   = 1'b1;
                        res.item[0].frame_length = clip16(sat_cnt[1]);
                        n_count = sat_cnt[1];
                    end
                end else if (r_match == 8'd0) begin
                    // length byte; zero is ignored
                    n_match = i_byte;
                end else begin
                    res.cnt                  = RES_CNT_W'(1);
                    res.item[0].payload_byte = i_byte;
                    res.item[0].byte_valid   = 1'b1;
                    res.item[0].frame_length = clip16(sat_cnt[1]);
                    n_count = sat_cnt[1];
                    if (32'(sat_cnt[1]) >= 32'(r_match)) begin
                        res.item[0].frame_done = 1'b1;
                        n_phase = PH_IDLE;
                        n_match = 8'd0;
                        n_count = '0;
                    end
                end
            end
            PH_TAIL: begin
                if (i_byte == tail_b) begin
                    if (mcp >= {4'd0, et}) begin
                        res.cnt                  = RES_CNT_W'(1);
                        res.item[0].frame_done   = 1'b1;
                        res.item[0].frame_length = clip16(r_count);
                        n_phase = PH_IDLE;
                        n_match = 8'd0;
                        n_count = '0;
                    end else begin
                        n_match = mcp;
                    end
                end else begin
                    // partial tail: release held tail bytes, then this byte
                    for (int i = 0; i < RES_LIMIT; i++) begin
                        if (3'(i) < {1'b0, flush_n}) begin
                            res.item[i].payload_byte =
                                pat_byte(i_cfg.tail_pattern, 8'(i));
                            res.item[i].byte_valid   = 1'b1;
                            res.item[i].frame_length = clip16(sat_cnt[i+1]);
                        end else if (3'(i) == {1'b0, flush_n}) begin
                            res.item[i].payload_byte = i_byte;
                            res.item[i].byte_valid   = 1'b1;
                            res.item[i].frame_length = clip16(sat_cnt[i+1]);
                        end
                    end
                    res.cnt = RES_CNT_W'(flush_n) + RES_CNT_W'(1);
                    n_count = sat_cnt[3'(flush_n) + 3'd1];
                    n_phase = PH_DATA;
                    n_match = 8'd0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_match = 8'd0;
                n_count = '0;
            end
        endcase
        if (res.cnt != '0) begin
            res.item[2'(res.cnt - RES_CNT_W'(1))].last = 1'b1;
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_match <= 8'd0;
            r_count <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_match <= n_match;
            r_count <= n_count;
        end
    end

endmodule

// ===== src/byte_frame_deframer.sv =====
// ============================================================================
// byte_frame_deframer - head/tail or head/length byte frame parser
// Registers, input stage, result buffer and output stream of the deframer.
// ============================================================================
// Usage:
//   Slave stream (s_*) takes one received byte per item in s_tdata.
//   Master stream (m_*) gives result items: payload byte and frame length in
//   m_tdata, byte-valid and frame-done flags in m_tuser; m_tlast marks the
//   last result caused by one received byte.
//   The APB port sets mode, head/tail lengths and patterns; write it only
//   while no byte is in flight.
//   An accepted byte is processed once the result buffer is free. Throughput
//   is one byte per cycle while m_tready is high and each byte gives at most
//   one result; a partial tail flush gives up to four results, which drain
//   one per cycle from the result buffer (m_tready high) as the input holds.
//   s_tready drops when the input register is full and the result buffer
//   still holds results that the receiver has not taken; m_tready low
//   therefore backs up into s_tready after one held byte.
//   Reset (synchronous, active low) restores the register defaults, returns
//   to head hunting and empties both stages.
module byte_frame_deframer #(
    parameter int MAX_HEAD_LEN = 4,
    parameter int MAX_TAIL_LEN = 4,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // receive stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] payload_byte, [23:8] frame_length
    output logic [1:0]  m_tuser,   // [0] byte_valid, [1] frame_done
    output logic        m_tlast,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bfd_pkg::*;

    t_cfg                r_cfg;
    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    t_result [RES_LIMIT-1:0] r_bank;
    logic [RES_CNT_W-1:0] r_left;
    logic [1:0]          r_idx;

    logic                cfg_wr;
    logic                bank_free;
    logic                proc;
    t_res_set            res;
    t_result             cur;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_mode   <= 1'b0;
            r_cfg.head_len     <= 3'd1;
            r_cfg.head_pattern <= 32'd0;
            r_cfg.tail_len     <= 3'd1;
            r_cfg.tail_pattern <= 32'd0;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_FRAME_MODE:   r_cfg.frame_mode   <= pwdata[0];
                REG_HEAD_LEN:     r_cfg.head_len     <= pwdata[2:0];
                REG_HEAD_PATTERN: r_cfg.head_pattern <= pwdata;
                REG_TAIL_LEN:     r_cfg.tail_len     <= pwdata[2:0];
                REG_TAIL_PATTERN: r_cfg.tail_pattern <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_FRAME_MODE:   prdata = {31'd0, r_cfg.frame_mode};
            REG_HEAD_LEN:     prdata = {29'd0, r_cfg.head_len};
            REG_HEAD_PATTERN: prdata = r_cfg.head_pattern;
            REG_TAIL_LEN:     prdata = {29'd0, r_cfg.tail_len};
            REG_TAIL_PATTERN: prdata = r_cfg.tail_pattern;
            default:          prdata = 32'd0;
        endcase
    end

    // Buffer frees when empty or its final result leaves this cycle
    assign bank_free = (r_left == '0) || ((r_left == RES_CNT_W'(1)) && m_tready);
    assign proc      = r_in_valid & bank_free;
    assign s_tready  = !r_in_valid || bank_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_byte <= s_tdata;
        end
    end

    bfd_parser #(
        .MAX_HEAD_LEN (MAX_HEAD_LEN),
        .MAX_TAIL_LEN (MAX_TAIL_LEN),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (proc),
        .i_byte  (r_in_byte),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    // Result buffer: load a byte's results, drain one per handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_idx  <= 2'd0;
        end else if (proc) begin
            r_left <= res.cnt;
            r_idx  <= 2'd0;
        end else if (m_tvalid && m_tready) begin
            r_left <= r_left - RES_CNT_W'(1);
            r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_bank <= res.item;
        end
    end

    assign cur      = r_bank[r_idx];
    assign m_tvalid = (r_left != '0);
    assign m_tdata  = {cur.frame_length, cur.payload_byte};
    assign m_tuser  = {cur.frame_done, cur.byte_valid};
    assign m_tlast  = cur.last;

`ifndef SYNTHESIS
    // buffer never holds more than one byte's results
    a_bank_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_left} + RES_CNT_W'(r_idx)) <= (RES_CNT_W+1)'(RES_LIMIT))
        else $error("result buffer overrun");

    // tlast only on the final buffered result
    a_last_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tlast) |-> (r_left == RES_CNT_W'(1)))
        else $error("tlast before final result");

    // a completed frame always closes a byte's results
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser[1]) |-> m_tlast)
        else $error("frame done not last");

    // input stalls only while a byte is held
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> (r_in_valid && m_tvalid))
        else $error("input stalled without held byte");
`endif

endmodule
